>>> rtl/core/hrlp_pkg.sv
// Package for the HTTP request line parser.
// Token classes, parse phases, keyword table and status codes; no dependencies.
`default_nettype none

package hrlp_pkg;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_WS,
    CLS_NUM,
    CLS_WORD,
    CLS_EOL
  } class_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SP1,
    PH_TARGET,
    PH_SP2,
    PH_VERSION,
    PH_EOL
  } phase_t;

  typedef enum logic [1:0] {
    MTH_NONE,
    MTH_GET,
    MTH_POST
  } method_t;

  typedef enum logic [1:0] {
    TGT_OTHER,
    TGT_DATA,
    TGT_ID
  } target_t;

  typedef enum logic [1:0] {
    FIN_CONT,
    FIN_BAD,
    FIN_DONE
  } fin_t;

  localparam logic [1:0] ST_BAD       = 2'd0;
  localparam logic [1:0] ST_OK_ID     = 2'd1;
  localparam logic [1:0] ST_OK_DATA   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic CFG_DATA_VALUE = 1'b0;
  localparam logic CFG_ID_TEXT    = 1'b1;

  localparam logic [15:0] DATA_VALUE_RST = 16'd234;
  localparam logic [63:0] ID_TEXT_RST    = 64'h0000_0000_0065_6F6A;

  localparam int KW_COUNT = 7;
  localparam int KW_GET   = 0;
  localparam int KW_POST  = 1;
  localparam int KW_DATA  = 2;
  localparam int KW_ID    = 3;
  localparam int KW_VER   = 4;
  localparam int KW_SP    = 5;
  localparam int KW_CRLF  = 6;

  // first character in bits 7:0
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0054_4547,   // GET
    64'h0000_0000_5453_4F50,   // POST
    64'h0000_0061_7461_642F,   // /data
    64'h0000_0000_0064_692F,   // /id
    64'h302E_312F_5054_5448,   // HTTP/1.0
    64'h0000_0000_0000_0020,   // space
    64'h0000_0000_0A0D_0A0D    // CR LF CR LF
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd5, 4'd3, 4'd8, 4'd1, 4'd4
  };

  typedef struct packed {
    class_t start;
    logic   cont;
  } cls_info_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] data;
    logic [63:0] id;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/hrlp_class.sv
// Byte classifier: start class of a byte and whether it extends the open token.
// Uses hrlp_pkg.
`default_nettype none

module hrlp_class
  import hrlp_pkg::*;
(
  input  wire logic [7:0] byte_in,
  input  wire class_t     tok_class,
  output cls_info_t       info
);

  logic letter, digit, mark, eol;

  assign letter = (byte_in >= 8'h61 && byte_in <= 8'h7A) ||
                  (byte_in >= 8'h41 && byte_in <= 8'h5A);
  assign digit  = byte_in >= 8'h30 && byte_in <= 8'h39;
  assign mark   = byte_in == 8'h5F || byte_in == 8'h2F ||
                  byte_in == 8'h2E || byte_in == 8'h2D;
  assign eol    = byte_in == 8'h0D || byte_in == 8'h0A;

  always_comb begin
    priority if (byte_in == 8'h20) info.start = CLS_WS;
    else if (digit)                info.start = CLS_NUM;
    else if (letter || mark)       info.start = CLS_WORD;
    else if (eol)                  info.start = CLS_EOL;
    else                           info.start = CLS_NONE;

    unique case (tok_class)
      CLS_WS:   info.cont = byte_in == 8'h20;
      CLS_NUM:  info.cont = digit;
      CLS_WORD: info.cont = letter || digit || mark;
      CLS_EOL:  info.cont = eol;
      default:  info.cont = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/hrlp_core.sv
// Parse state and per-word step logic: tokens, keyword matching, phase tracking.
// Uses hrlp_pkg and hrlp_class.
`default_nettype none

module hrlp_core
  import hrlp_pkg::*;
#(
  parameter int TOKEN_MAX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  byte_in,
  input  wire logic        end_of_input,
  input  wire logic [15:0] data_value,
  input  wire logic [63:0] id_text,
  output res_t             res
);

  localparam int LEN_W = $clog2(TOKEN_MAX + 1);

  phase_t              phase, phase_next;
  class_t              tok_class, tok_class_next;
  logic [LEN_W-1:0]    tok_len, tok_len_next;
  logic [KW_COUNT-1:0] kw_match, kw_match_next;
  method_t             method_seen, method_seen_next;
  target_t             target_seen, target_seen_next;

  cls_info_t           cls;
  logic [KW_COUNT-1:0] kw_first, kw_step, kw_full;
  fin_t                fin;
  phase_t              fin_phase;
  method_t             fin_method;
  target_t             fin_target;

  logic tok_open, len_at_max;
  logic do_resp, do_done, do_restart, do_open, do_take, do_apply;

  hrlp_class u_class (
    .byte_in   (byte_in),
    .tok_class (tok_class),
    .info      (cls)
  );

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_first[k] = byte_in == KW_TEXT[k][7:0];
      kw_step[k]  = kw_match[k] && (tok_len < LEN_W'(KW_LEN[k])) &&
                    byte_in == KW_TEXT[k][8*tok_len[2:0] +: 8];
      kw_full[k]  = kw_match[k] && tok_len == LEN_W'(KW_LEN[k]);
    end
  end

  // judge the open token against the expected phase
  always_comb begin
    fin        = FIN_BAD;
    fin_phase  = phase;
    fin_method = method_seen;
    fin_target = target_seen;
    unique case (phase)
      PH_METHOD: begin
        if (tok_class == CLS_WORD && kw_full[KW_GET]) begin
          fin = FIN_CONT; fin_phase = PH_SP1; fin_method = MTH_GET;
        end else if (tok_class == CLS_WORD && kw_full[KW_POST]) begin
          fin = FIN_CONT; fin_phase = PH_SP1; fin_method = MTH_POST;
        end
      end
      PH_SP1: begin
        if (tok_class == CLS_WS && kw_full[KW_SP]) begin
          fin = FIN_CONT; fin_phase = PH_TARGET;
        end
      end
      PH_TARGET: begin
        if (tok_class == CLS_WORD) begin
          fin = FIN_CONT; fin_phase = PH_SP2;
          fin_target = kw_full[KW_DATA] ? TGT_DATA : (kw_full[KW_ID] ? TGT_ID : TGT_OTHER);
        end
      end
      PH_SP2: begin
        if (tok_class == CLS_WS && kw_full[KW_SP]) begin
          fin = FIN_CONT; fin_phase = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (tok_class == CLS_WORD && kw_full[KW_VER]) begin
          fin = FIN_CONT; fin_phase = PH_EOL;
        end
      end
      PH_EOL: begin
        if (tok_class == CLS_EOL && kw_full[KW_CRLF]) fin = FIN_DONE;
      end
      default: fin = FIN_BAD;
    endcase
  end

  assign tok_open   = tok_class != CLS_NONE;
  assign len_at_max = tok_len >= LEN_W'(TOKEN_MAX);

  // what this word does
  always_comb begin
    do_resp    = 1'b0;
    do_done    = 1'b0;
    do_restart = 1'b0;
    do_open    = 1'b0;
    do_take    = 1'b0;
    do_apply   = 1'b0;
    if (end_of_input) begin
      do_resp    = 1'b1;
      do_done    = tok_open && fin == FIN_DONE;
      do_restart = 1'b1;
    end else if (tok_open) begin
      if (len_at_max) begin
        do_resp    = 1'b1;
        do_restart = 1'b1;
        do_open    = cls.start != CLS_NONE;
      end else if (cls.cont) begin
        do_take = 1'b1;
      end else if (fin == FIN_CONT) begin
        do_apply = 1'b1;
        if (cls.start != CLS_NONE) begin
          do_open = 1'b1;
        end else begin
          do_resp    = 1'b1;
          do_restart = 1'b1;
        end
      end else begin
        do_resp    = 1'b1;
        do_done    = fin == FIN_DONE;
        do_restart = 1'b1;
        do_open    = cls.start != CLS_NONE;
      end
    end else if (cls.start != CLS_NONE) begin
      do_open = 1'b1;
    end else begin
      do_resp    = 1'b1;
      do_restart = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    tok_class_next   = tok_class;
    tok_len_next     = tok_len;
    kw_match_next    = kw_match;
    method_seen_next = method_seen;
    target_seen_next = target_seen;
    if (do_apply) begin
      phase_next       = fin_phase;
      method_seen_next = fin_method;
      target_seen_next = fin_target;
      tok_class_next   = CLS_NONE;
    end
    if (do_restart) begin
      phase_next       = PH_METHOD;
      method_seen_next = MTH_NONE;
      target_seen_next = TGT_OTHER;
      tok_class_next   = CLS_NONE;
      tok_len_next     = '0;
      kw_match_next    = '1;
    end
    if (do_open) begin
      tok_class_next = cls.start;
      tok_len_next   = LEN_W'(1);
      kw_match_next  = kw_first;
    end
    if (do_take) begin
      tok_len_next  = tok_len + LEN_W'(1);
      kw_match_next = kw_step;
    end
  end

  // result word
  always_comb begin
    res.valid  = fire && do_resp;
    res.status = ST_BAD;
    res.data   = '0;
    res.id     = '0;
    if (do_done) begin
      if (method_seen == MTH_GET && target_seen == TGT_ID) begin
        res.status = ST_OK_ID;
        res.id     = id_text;
      end else if (method_seen == MTH_GET && target_seen == TGT_DATA) begin
        res.status = ST_OK_DATA;
        res.data   = data_value;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_METHOD;
      tok_class   <= CLS_NONE;
      tok_len     <= '0;
      kw_match    <= '1;
      method_seen <= MTH_NONE;
      target_seen <= TGT_OTHER;
    end else if (fire) begin
      phase       <= phase_next;
      tok_class   <= tok_class_next;
      tok_len     <= tok_len_next;
      kw_match    <= kw_match_next;
      method_seen <= method_seen_next;
      target_seen <= target_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/http_request_line_parser.sv
// HTTP/1.0 request line parser, one request byte per word.
// Top level: input register, config registers, output register; uses hrlp_pkg,
// hrlp_core.
//
// Input channel (in_valid/in_ready): byte_in, or end_of_input set to close the
// stream. Output channel (out_valid/out_ready): one word per request with
// status, data_out and id_out. Words that do not end a request give nothing.
// Configuration: cfg_wen with cfg_index 0 writes data_value, 1 writes id_text;
// write only while the block is idle.
// An input word is held in the input register, judged by hrlp_core and its
// response is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the token,
// keyword and phase state is updated once per word by one stage of logic.
// When the receiver stalls, the output word holds and the input register keeps
// the next byte; in_ready drops only while the input register holds a byte and
// an output word waits with out_ready low.
// Reset clears the parse state, empties both registers and sets data_value to
// 234 and id_text to "joe".
`default_nettype none

module http_request_line_parser
  import hrlp_pkg::*;
#(
  parameter int TOKEN_MAX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      data_out,
  output logic [63:0]      id_out,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [15:0] data_value;
  logic [63:0] id_text;

  logic        in_v;
  logic [7:0]  in_byte;
  logic        in_eoi;
  logic        adv;
  logic        fire;
  res_t        res;

  assign adv      = !out_valid || out_ready;
  assign fire     = in_v && adv;
  assign in_ready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_value <= DATA_VALUE_RST;
      id_text    <= ID_TEXT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_DATA_VALUE: data_value <= cfg_data[15:0];
        CFG_ID_TEXT:    id_text    <= cfg_data;
        default:        id_text    <= id_text;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= byte_in;
      in_eoi  <= end_of_input;
    end
  end

  hrlp_core #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .byte_in      (in_byte),
    .end_of_input (in_eoi),
    .data_value   (data_value),
    .id_text      (id_text),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      status   <= res.status;
      data_out <= res.data;
      id_out   <= res.id;
    end
  end

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK_DATA |-> data_out == 16'd0)
    else $error("data_out nonzero without ok data status");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK_ID |-> id_out == 64'd0)
    else $error("id_out nonzero without ok id status");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present after reset");

endmodule

`default_nettype wire
